@@ src/adsr_pkg.sv @@
package adsr_pkg;

  localparam int unsigned RateW  = 4;
  localparam int unsigned LevelW = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned DivW   = 21;
  localparam int unsigned TblW   = 16;
  localparam int unsigned FacW   = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PhaseW-1:0] PhIdle    = 3'd0;
  localparam logic [PhaseW-1:0] PhAttack  = 3'd1;
  localparam logic [PhaseW-1:0] PhDecay   = 3'd2;
  localparam logic [PhaseW-1:0] PhSustain = 3'd3;
  localparam logic [PhaseW-1:0] PhRelease = 3'd4;

  localparam logic [CfgIdxW-1:0] RegAttack  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDecay   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSustain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRelease = 3'd3;

  localparam logic [LevelW-1:0] LevelMax = 8'd255;
  localparam logic [DivW-1:0]   DivMax   = {DivW{1'b1}};

  typedef struct packed {
    logic [RateW-1:0] attack_rate;
    logic [RateW-1:0] decay_rate;
    logic [RateW-1:0] sustain_level;
    logic [RateW-1:0] release_rate;
  } adsr_cfg_t;

  // Tick count per level step for each rate setting.
  function automatic logic [TblW-1:0] rate_period(input logic [RateW-1:0] rate);
    logic [TblW-1:0] p;
    case (rate)
      4'd0:    p = 16'd9;
      4'd1:    p = 16'd32;
      4'd2:    p = 16'd63;
      4'd3:    p = 16'd95;
      4'd4:    p = 16'd149;
      4'd5:    p = 16'd220;
      4'd6:    p = 16'd267;
      4'd7:    p = 16'd313;
      4'd8:    p = 16'd392;
      4'd9:    p = 16'd977;
      4'd10:   p = 16'd1954;
      4'd11:   p = 16'd3126;
      4'd12:   p = 16'd6252;
      4'd13:   p = 16'd15625;
      4'd14:   p = 16'd31250;
      default: p = 16'd62500;
    endcase
    return p;
  endfunction

  // Piecewise exponential slow-down for falling phases, chosen by level.
  function automatic logic [FacW-1:0] exp_factor(input logic [LevelW-1:0] lvl);
    logic [FacW-1:0] f;
    if (lvl <= 8'd5)       f = 5'd30;
    else if (lvl <= 8'd13) f = 5'd16;
    else if (lvl <= 8'd25) f = 5'd8;
    else if (lvl <= 8'd53) f = 5'd4;
    else if (lvl <= 8'd92) f = 5'd2;
    else                   f = 5'd1;
    return f;
  endfunction

endpackage

@@ src/adsr_envelope_generator.sv @@
// Output: a tick's result is registered and shown in the cycle after its acceptance.
// Throughput: one tick per cycle unless a held result stalls it; the envelope state
// advances in a single pass of table lookup, small multiply and divider compare.
// Reset: asynchronous, active low; clears the configuration and the envelope
// state to zero, phase idle, level zero, and leaves no result pending.
module adsr_envelope_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [adsr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [adsr_pkg::RateW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         gate_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [adsr_pkg::LevelW-1:0]  env_level_o,
  output logic [adsr_pkg::PhaseW-1:0]  env_phase_o
);
  import adsr_pkg::*;

  // Configuration registers, written by index; unknown indexes are dropped.
  adsr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAttack:  cfg_q.attack_rate   <= cfg_data_i;
        RegDecay:   cfg_q.decay_rate    <= cfg_data_i;
        RegSustain: cfg_q.sustain_level <= cfg_data_i;
        RegRelease: cfg_q.release_rate  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Envelope state.
  logic              prev_gate_q, prev_gate_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [DivW-1:0]   div_q, div_d;
  logic [LevelW-1:0] level_q, level_d;

  // Result register; the output side is decoupled so a tick is taken whenever
  // the held result is leaving or there is none.
  logic              out_valid_q;
  logic [LevelW-1:0] out_level_q;
  logic [PhaseW-1:0] out_phase_q;

  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Phase after the gate edge check; the step logic works from this phase.
  logic [PhaseW-1:0] phase_gate;
  always_comb begin
    phase_gate = phase_q;
    if (!prev_gate_q && gate_i)      phase_gate = PhAttack;
    else if (prev_gate_q && !gate_i) phase_gate = PhRelease;
  end

  // The threshold uses the level before this tick's step.
  logic [DivW-1:0] thresh;
  adsr_thresh u_thresh (
    .cfg_i    (cfg_q),
    .phase_i  (phase_gate),
    .level_i  (level_q),
    .thresh_o (thresh)
  );

  // The divider saturates instead of wrapping, then a step is due once it
  // reaches the threshold; it carries over across phase changes.
  logic [DivW-1:0]   div_inc;
  logic              step_due;
  logic [LevelW-1:0] sustain_target;

  assign div_inc        = (div_q != DivMax) ? div_q + DivW'(1) : div_q;
  assign step_due       = (div_inc >= thresh);
  assign sustain_target = {cfg_q.sustain_level, cfg_q.sustain_level};

  always_comb begin
    prev_gate_d = gate_i;
    phase_d     = phase_gate;
    div_d       = div_q;
    level_d     = level_q;
    case (phase_gate)
      PhAttack: begin
        div_d = step_due ? '0 : div_inc;
        if (step_due && level_q != LevelMax) level_d = level_q + LevelW'(1);
        if (level_d == LevelMax) phase_d = PhDecay;
      end
      PhDecay: begin
        // Decay keeps falling even if sustain was raised above the level;
        // it then rests at zero while still in decay.
        div_d = step_due ? '0 : div_inc;
        if (step_due && level_q != '0) level_d = level_q - LevelW'(1);
        if (level_d == sustain_target) phase_d = PhSustain;
      end
      PhSustain: begin
      end
      PhRelease: begin
        div_d = step_due ? '0 : div_inc;
        if (step_due && level_q != '0) level_d = level_q - LevelW'(1);
        if (level_d == '0) phase_d = PhIdle;
      end
      default: begin
        // Idle, and any unused code, pins the level at zero.
        phase_d = PhIdle;
        level_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_gate_q <= 1'b0;
      phase_q     <= PhIdle;
      div_q       <= '0;
      level_q     <= '0;
    end else if (accept) begin
      prev_gate_q <= prev_gate_d;
      phase_q     <= phase_d;
      div_q       <= div_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_level_q <= level_d;
      out_phase_q <= phase_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign env_level_o = out_level_q;
  assign env_phase_o = out_phase_q;

endmodule

@@ src/adsr_thresh.sv @@
module adsr_thresh (
  input  adsr_pkg::adsr_cfg_t         cfg_i,
  input  logic [adsr_pkg::PhaseW-1:0] phase_i,
  input  logic [adsr_pkg::LevelW-1:0] level_i,
  output logic [adsr_pkg::DivW-1:0]   thresh_o
);
  import adsr_pkg::*;

  logic [RateW-1:0] rate;
  logic [FacW-1:0]  factor;

  always_comb begin
    case (phase_i)
      PhAttack: begin
        rate   = cfg_i.attack_rate;
        factor = FacW'(1);
      end
      PhDecay: begin
        rate   = cfg_i.decay_rate;
        factor = exp_factor(level_i);
      end
      default: begin
        rate   = cfg_i.release_rate;
        factor = exp_factor(level_i);
      end
    endcase
  end

  // Largest product is 62500 * 30, which fits the divider width.
  assign thresh_o = DivW'(rate_period(rate)) * DivW'(factor);

endmodule

@@ tb/sv/adsr_envelope_generator_tb.sv @@
module adsr_envelope_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_pkg::*;

  // Ticks per level step for each rate setting. The prediction keeps its own copy
  // of this table so that a wrong entry in the design cannot hide itself.
  localparam int unsigned StepTicks [16] = '{
    9, 32, 63, 95, 149, 220, 267, 313,
    392, 977, 1954, 3126, 6252, 15625, 31250, 62500
  };

  // Marks a stop condition of hold_gate as unused.
  localparam int NoStop = -1;

  // One envelope result: the level and the phase after a tick.
  typedef struct {
    logic [LevelW-1:0] level;
    logic [PhaseW-1:0] phase;
  } envelope_t;

  // The scoreboard follows the envelope tick by tick. Each accepted tick request
  // advances its own copy of the state and queues the result that the tick must
  // produce; each result from the block is then checked against the oldest one.
  class envelope_scoreboard;
    adsr_cfg_t         cfg;
    bit                last_gate;
    logic [PhaseW-1:0] phase;
    logic [LevelW-1:0] level;
    int unsigned       divider;
    envelope_t         envelope_q[$];
    int unsigned       mismatches;
    int unsigned       ticks;
    int unsigned       results;
    bit [7:0]          seen_phases;

    function new();
      cfg         = '0;
      last_gate   = 1'b0;
      phase       = PhIdle;
      level       = '0;
      divider     = 0;
      mismatches  = 0;
      ticks       = 0;
      results     = 0;
      seen_phases = '0;
    endfunction

    // Writes to indexes past the last register are dropped, as in the block.
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] data);
      case (idx)
        RegAttack:  cfg.attack_rate   = data;
        RegDecay:   cfg.decay_rate    = data;
        RegSustain: cfg.sustain_level = data;
        RegRelease: cfg.release_rate  = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return envelope_q.size();
    endfunction

    // Counts one tick and reports whether a level step is due. The count is not
    // cleared on a phase change, so a count left over from a slow phase can make
    // the first step of a faster phase come on the very next tick.
    function bit count_step(int unsigned limit);
      if (divider < DivMax) divider++;
      if (divider >= limit) begin
        divider = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Falling phases slow down as the level gets lower, in coarse segments.
    function int unsigned fall_scale(int unsigned lvl);
      if (lvl <= 5) return 30;
      if (lvl <= 13) return 16;
      if (lvl <= 25) return 8;
      if (lvl <= 53) return 4;
      if (lvl <= 92) return 2;
      return 1;
    endfunction

    function void note_tick(logic g);
      envelope_t e;
      // Gate edges take priority over whatever phase the envelope is in.
      if (!last_gate && g) phase = PhAttack;
      else if (last_gate && !g) phase = PhRelease;
      last_gate = g;

      case (phase)
        PhAttack: begin
          // The level saturates at full scale; a new attack that starts there
          // turns into decay on the same tick.
          if (count_step(StepTicks[cfg.attack_rate]) && level != LevelMax) level++;
          if (level == LevelMax) phase = PhDecay;
        end
        PhDecay: begin
          // Decay stops at the sustain target. If the target was raised above
          // the level, decay keeps going down and rests at zero.
          if (count_step(StepTicks[cfg.decay_rate] * fall_scale(level)) && level != 0)
            level--;
          if (int'(level) == 17 * int'(cfg.sustain_level)) phase = PhSustain;
        end
        PhSustain: ;
        PhRelease: begin
          if (count_step(StepTicks[cfg.release_rate] * fall_scale(level)) && level != 0)
            level--;
          if (level == 0) phase = PhIdle;
        end
        default: begin
          phase = PhIdle;
          level = '0;
        end
      endcase

      e.level = level;
      e.phase = phase;
      envelope_q.push_back(e);
      ticks++;
    endfunction

    function void check_result(logic [LevelW-1:0] lvl, logic [PhaseW-1:0] ph);
      envelope_t e;
      results++;
      seen_phases[ph] = 1'b1;
      if (envelope_q.size() == 0) begin
        $error("result with no tick request pending: env_level %0d, env_phase %0d", lvl, ph);
        mismatches++;
        return;
      end
      e = envelope_q.pop_front();
      if (lvl !== e.level) begin
        $error("env_level mismatch: expected %0d, actual %0d", e.level, lvl);
        mismatches++;
      end
      if (ph !== e.phase) begin
        $error("env_phase mismatch: expected %0d, actual %0d", e.phase, ph);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [RateW-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 gate_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [LevelW-1:0]    env_level_o;
  logic [PhaseW-1:0]    env_phase_o;

  envelope_scoreboard sb;

  // When the stimulus sets this, the result side holds off while tick requests
  // keep coming, so the block fills up and stalls its input.
  int holdoff_cycles = 0;
  // When set, the request side sends back to back without any gaps.
  bit sender_steady = 1'b0;
  int settings = 0;

  adsr_envelope_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .gate_i      (gate_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .env_level_o (env_level_o),
    .env_phase_o (env_phase_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps between tick requests, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Rates lean toward the fastest settings so that the envelope actually moves
  // within a few hundred ticks; the slow ones still show up.
  function automatic logic [RateW-1:0] pick_rate();
    if ($urandom_range(0, 2) != 0) return RateW'($urandom_range(0, 1));
    return RateW'($urandom_range(0, 15));
  endfunction

  // Offers one tick request after a random gap and waits for it to be taken.
  // Valid stays high with the gate unchanged until the handshake completes.
  task automatic send_tick(logic g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    gate_i     <= g;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(g);
  endtask

  // Sends the same gate level for up to max_ticks ticks. It stops early once
  // the predicted phase reaches stop_phase or the predicted level falls to
  // stop_level, whichever of the two is in use.
  task automatic hold_gate(logic g, int max_ticks, int stop_phase, int stop_level);
    for (int i = 0; i < max_ticks; i++) begin
      send_tick(g);
      if (stop_phase != NoStop && int'(sb.phase) == stop_phase) break;
      if (stop_level != NoStop && int'(sb.level) <= stop_level) break;
    end
  endtask

  // Stops offering requests and waits until every result has come back, so that
  // a register write cannot overtake a tick.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Writes all four registers and, now and then, an index past the last one,
  // which the block has to ignore.
  task automatic apply_setting(logic [RateW-1:0] a, logic [RateW-1:0] d,
                               logic [RateW-1:0] s, logic [RateW-1:0] r);
    logic [CfgIdxW-1:0] stray;
    drain_requests();
    set_register(RegAttack, a);
    set_register(RegDecay, d);
    set_register(RegSustain, s);
    set_register(RegRelease, r);
    if ($urandom_range(0, 2) == 0) begin
      stray = RegRelease + 3'd1 + 3'($urandom_range(0, 3));
      set_register(stray, RateW'($urandom_range(0, 15)));
    end
    settings++;
  endtask

  // Every result taken by the testbench is checked at the edge where the
  // handshake completes. Values are read before that edge updates anything.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(env_level_o, env_phase_o);
  end

  // The result side: long stretches of steady readiness, short stalls, rare
  // long stalls, and the forced hold-off that the stimulus asks for.
  initial begin : result_side
    int n;
    int r;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (holdoff_cycles > 0) begin
        n = holdoff_cycles;
        holdoff_cycles = 0;
        out_ready_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready_i <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 70) begin
          out_ready_i <= 1'b1;
          n = $urandom_range(100, 300);
        end else if (r < 95) begin
          out_ready_i <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          out_ready_i <= 1'b0;
          n = $urandom_range(10, 60);
        end
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // A correct run has at most some 2500 ticks, each behind the longest request
  // gap and the longest stall of the result side, well under 2 ms in all. The
  // limit is several times that.
  initial begin
    #10ms;
    $display("adsr_envelope_generator_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    // Directed gate pattern, sent from the most significant bit down: single
    // ticks of each level, quick toggles, and a hold long enough for the first
    // attack step at the fastest rate.
    localparam bit [25:0] DirectedGate = 26'b00111001011111111111101000;
    int random_ticks;
    int budget;
    int n;
    int r;
    int hi;
    int lo;
    int k;
    int setting_no;

    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    gate_i      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= RegAttack;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at the lowest settings.
    apply_setting(4'd0, 4'd0, 4'd0, 4'd0);
    for (int i = 25; i >= 0; i--) send_tick(DirectedGate[i]);
    // Keep the gate low until the level has released all the way to idle.
    hold_gate(1'b0, 600, PhIdle, NoStop);

    // Random part. Every setting gets a batch of notes with random lengths,
    // some gate noise and quick retriggers. Register writes land at whatever
    // point the envelope has reached, so a phase may see its rate or its
    // target change under it.
    random_ticks = 0;
    setting_no = 0;
    while (random_ticks < 1100) begin
      case (setting_no)
        0: apply_setting(4'd15, 4'd15, 4'd15, 4'd15);
        1: apply_setting(4'd0, 4'd15, 4'd0, 4'd15);
        2: apply_setting(4'd15, 4'd0, 4'd15, 4'd0);
        default: apply_setting(pick_rate(), pick_rate(), RateW'($urandom_range(0, 15)),
                               pick_rate());
      endcase
      if (setting_no == 1 || setting_no == 6) holdoff_cycles = 400;
      sender_steady = ($urandom_range(0, 3) == 0);
      budget = $urandom_range(80, 160);
      n = 0;
      while (n < budget) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          hi = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 60);
          lo = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 60);
          hold_gate(1'b1, hi, NoStop, NoStop);
          hold_gate(1'b0, lo, NoStop, NoStop);
          n += hi + lo;
        end else if (r < 85) begin
          k = $urandom_range(1, 20);
          repeat (k) send_tick(1'($urandom_range(0, 1)));
          n += k;
        end else begin
          hi = $urandom_range(1, 30);
          lo = $urandom_range(1, 3);
          k  = $urandom_range(1, 30);
          hold_gate(1'b1, hi, NoStop, NoStop);
          hold_gate(1'b0, lo, NoStop, NoStop);
          hold_gate(1'b1, k, NoStop, NoStop);
          n += hi + lo + k;
        end
      end
      random_ticks += n;
      setting_no++;
    end

    // Let the last results come back, with a bound in case they never do.
    in_valid_i <= 1'b0;
    for (int w = 0; w < 20000 && sb.pending() != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Checked %0d results for %0d tick requests under %0d register settings.",
             sb.results, sb.ticks, settings);
    $display("Envelope phases seen in results (release down to idle): %05b",
             sb.seen_phases[4:0]);
    if (sb.mismatches == 0) begin
      $display("adsr_envelope_generator_tb OK");
    end else begin
      $display("adsr_envelope_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ adsr_envelope_generator.f @@
src/adsr_pkg.sv
src/adsr_thresh.sv
src/adsr_envelope_generator.sv
tb/sv/adsr_envelope_generator_tb.sv
